// ===== hdl/bfm3_pkg.sv =====
// shared types and constants for the bloom filter murmur3 core
`timescale 1ns / 1ps
`default_nettype none
package bfm3_pkg;

    localparam int NUM_SEEDS  = 8;
    localparam int KEY_WORDS  = 5;
    localparam int ADDR_MAX_W = 20;

    localparam logic [31:0] MUR_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2   = 32'h1b873593;
    localparam logic [31:0] MUR_ADD  = 32'he6546b64;
    localparam logic [31:0] MUR_F1   = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2   = 32'hc2b2ae35;
    localparam logic [31:0] KEY_LEN  = 32'd20;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   last;
        logic [ADDR_MAX_W-1:0]  addr;
    } cmd_t;

    typedef logic [NUM_SEEDS-1:0][31:0] seed_array_t;

endpackage
`default_nettype wire

// ===== hdl/bloom_filter_murmur3_core.sv =====
// top level of the bloom filter core with murmur3 x86_32 addressing
//
// channel   direction  handshake            payload
// in        to core    in_valid / in_stall  action, key_word0..key_word4
// out       from core  out_valid/out_stall  maybe_present
// cfg       to core    cfg_we               cfg_index, cfg_data (seed_0..seed_7)
//
// key mixing runs first, then each hash runs its rounds and finalizer, plus a restoring remainder
// when FILTER_BITS is not a power of two, all on one shared 32x32 multiplier
// clear: one 32-bit memory row per cycle
// after reset a clearing pass over every memory row runs; in_stall stays high
// commands queue four deep, so hashing runs ahead while the result register is stalled
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_murmur3_core #(
    parameter int NUM_HASHES  = 4,
    parameter int FILTER_BITS = 65536
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  action,
    input  wire  [31:0] key_word0,
    input  wire  [31:0] key_word1,
    input  wire  [31:0] key_word2,
    input  wire  [31:0] key_word3,
    input  wire  [31:0] key_word4,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        maybe_present,
    input  wire         cfg_we,
    input  wire  [3:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    // seed registers, reset value equals their index
    bfm3_pkg::seed_array_t seed_reg;

    logic            init_busy;
    logic            q_push, q_full, q_pop, q_not_empty;
    bfm3_pkg::cmd_t  push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfm3_pkg::NUM_SEEDS; i++)
                seed_reg[i] <= 32'(i);
        end
        else if (cfg_we && !cfg_index[3])
            seed_reg[cfg_index[2:0]] <= cfg_data;
    end

    // hash front end
    bfm3_front #(
        .NUM_HASHES  (NUM_HASHES),
        .FILTER_BITS (FILTER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .key_word0 (key_word0),
        .key_word1 (key_word1),
        .key_word2 (key_word2),
        .key_word3 (key_word3),
        .key_word4 (key_word4),
        .seeds     (seed_reg),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    // decoupling queue of bit commands
    bfm3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    // bit memory back end
    bfm3_back #(
        .FILTER_BITS (FILTER_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .init_busy     (init_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .maybe_present (maybe_present)
    );

endmodule
`default_nettype wire

// ===== hdl/bfm3_front.sv =====
// front end: accepts words, hashes the key per seed and issues bit commands
`timescale 1ns / 1ps
`default_nettype none
module bfm3_front #(
    parameter int NUM_HASHES  = 4,
    parameter int FILTER_BITS = 65536
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire  [1:0]            action,
    input  wire  [31:0]           key_word0,
    input  wire  [31:0]           key_word1,
    input  wire  [31:0]           key_word2,
    input  wire  [31:0]           key_word3,
    input  wire  [31:0]           key_word4,
    input  wire  bfm3_pkg::seed_array_t seeds,
    input  wire                   init_busy,
    input  wire                   q_full,
    output logic                  q_push,
    output bfm3_pkg::cmd_t        q_data
);
    localparam int AW = $clog2(FILTER_BITS);
    localparam bit IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;
    localparam logic [AW:0] FB = (AW+1)'(FILTER_BITS);
    localparam logic [3:0] LAST_SEED = 4'(NUM_HASHES - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MIXA, ST_MIXB, ST_ROUND, ST_FIN1, ST_FIN2, ST_FIN3, ST_MOD, ST_PUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic [31:0]             key_reg [bfm3_pkg::KEY_WORDS];
    logic [31:0]             km_reg  [bfm3_pkg::KEY_WORDS];
    logic [31:0]             t_reg, t_next;
    logic [31:0]             h_reg, h_next;
    logic [AW-1:0]           r_reg, r_next;
    logic [2:0]              w_reg, w_next;
    logic [3:0]              s_reg, s_next;
    logic [2:0]              m_reg, m_next;
    logic                    accept;

    logic [31:0]             mul_a, mul_b;
    logic [63:0]             prod;
    logic [31:0]             x, y;
    logic [AW:0]             rr;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || init_busy;
    assign prod     = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        x = h_reg ^ km_reg[w_reg];
        x = {x[18:0], x[31:19]};
        y = h_reg ^ bfm3_pkg::KEY_LEN;
        y = y ^ (y >> 16);
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_MIXA: begin mul_a = key_reg[w_reg];              mul_b = bfm3_pkg::MUR_C1; end
            ST_MIXB: begin mul_a = {t_reg[16:0], t_reg[31:17]}; mul_b = bfm3_pkg::MUR_C2; end
            ST_FIN1: begin mul_a = y;                           mul_b = bfm3_pkg::MUR_F1; end
            ST_FIN2: begin mul_a = h_reg ^ (h_reg >> 13);       mul_b = bfm3_pkg::MUR_F2; end
            default: begin mul_a = 32'd0;                       mul_b = 32'd0;            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        t_next     = t_reg;
        h_next     = h_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        q_push     = 1'b0;
        q_data.kind = (op_reg == bfm3_pkg::ACT_INSERT) ? bfm3_pkg::CMD_SET :
                      (op_reg == bfm3_pkg::ACT_QUERY)  ? bfm3_pkg::CMD_TEST :
                                                         bfm3_pkg::CMD_CLEAR;
        q_data.last = (op_reg == bfm3_pkg::ACT_CLEAR) || (s_reg == LAST_SEED);
        q_data.addr = bfm3_pkg::ADDR_MAX_W'(r_reg);
        rr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = action;
                    w_next  = 3'd0;
                    s_next  = 4'd0;
                    case (action)
                        bfm3_pkg::ACT_INSERT, bfm3_pkg::ACT_QUERY: state_next = ST_MIXA;
                        bfm3_pkg::ACT_CLEAR:                       state_next = ST_PUSH;
                        default:                                   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MIXA:
            begin
                t_next     = prod[31:0];
                state_next = ST_MIXB;
            end
            ST_MIXB:
            begin
                if (w_reg == 3'd4)
                begin
                    w_next     = 3'd0;
                    h_next     = seeds[3'd0];
                    state_next = ST_ROUND;
                end
                else
                begin
                    w_next     = w_reg + 3'd1;
                    state_next = ST_MIXA;
                end
            end
            ST_ROUND:
            begin
                h_next = {x[29:0], 2'b00} + x + bfm3_pkg::MUR_ADD;
                if (w_reg == 3'd4)
                    state_next = ST_FIN1;
                else
                    w_next = w_reg + 3'd1;
            end
            ST_FIN1:
            begin
                h_next     = prod[31:0];
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                h_next     = prod[31:0];
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                h_next     = h_reg ^ (h_reg >> 16);
                r_next     = '0;
                m_next     = 3'd0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (IS_POW2)
                begin
                    r_next     = h_reg[AW-1:0];
                    state_next = ST_PUSH;
                end
                else
                begin
                    // restoring remainder, four hash bits per cycle
                    rr = {1'b0, r_reg};
                    for (int b = 0; b < 4; b++)
                    begin
                        rr = {rr[AW-1:0], h_reg[31-b]};
                        if (rr >= FB)
                            rr = rr - FB;
                    end
                    r_next = rr[AW-1:0];
                    h_next = {h_reg[27:0], 4'd0};
                    m_next = m_reg + 3'd1;
                    if (m_reg == 3'd7)
                        state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    if (q_data.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        s_next     = s_reg + 4'd1;
                        h_next     = seeds[s_next[2:0]];
                        w_next     = 3'd0;
                        state_next = ST_ROUND;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        t_reg  <= t_next;
        h_reg  <= h_next;
        r_reg  <= r_next;
        w_reg  <= w_next;
        s_reg  <= s_next;
        m_reg  <= m_next;
        if (accept)
        begin
            key_reg[0] <= key_word0;
            key_reg[1] <= key_word1;
            key_reg[2] <= key_word2;
            key_reg[3] <= key_word3;
            key_reg[4] <= key_word4;
        end
        if (state_reg == ST_MIXB)
            km_reg[w_reg] <= prod[31:0];
    end

endmodule
`default_nettype wire

// ===== hdl/bfm3_queue.sv =====
// four-entry command queue between hash front end and memory back end
`timescale 1ns / 1ps
`default_nettype none
module bfm3_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  wire  bfm3_pkg::cmd_t push_data,
    output logic            full,
    input  wire             pop,
    output logic            not_empty,
    output bfm3_pkg::cmd_t  pop_data
);
    bfm3_pkg::cmd_t entry_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == 3'd4;
    assign not_empty = cnt_reg != 3'd0;
    assign pop_data  = entry_reg[rd_reg];
    assign cnt_next  = cnt_reg + {2'd0, push} - {2'd0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 2'd1;
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== hdl/bfm3_back.sv =====
// back end: filter bit memory, clearing sweep and query result register
`timescale 1ns / 1ps
`default_nettype none
module bfm3_back #(
    parameter int FILTER_BITS = 65536
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             q_not_empty,
    input  wire  bfm3_pkg::cmd_t q_data,
    output logic            q_pop,
    output logic            init_busy,
    output logic            out_valid,
    input  wire             out_stall,
    output logic            maybe_present
);
    localparam int AW   = $clog2(FILTER_BITS);
    localparam int RW   = AW - 5;
    localparam int ROWS = (FILTER_BITS + 31) / 32;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    typedef enum logic [1:0] {ST_INIT, ST_RUN, ST_CLR} state_t;

    state_t         state_reg;
    logic [31:0]    mem [ROWS];
    logic [31:0]    rdata_reg;
    logic [RW-1:0]  ctr_reg;
    logic           pend_reg, pend_last_reg, acc_reg, out_valid_reg, maybe_reg;
    logic [4:0]     pend_bit_reg;
    logic [RW-1:0]  row;
    logic [4:0]     bitn;
    logic           out_free, hit;
    logic           sweeping;
    logic           result_load;

    assign row       = q_data.addr[AW-1:5];
    assign bitn      = q_data.addr[4:0];
    assign sweeping  = (state_reg == ST_INIT) || (state_reg == ST_CLR);
    assign init_busy = state_reg == ST_INIT;
    assign q_pop     = (state_reg == ST_RUN) && q_not_empty && !pend_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign hit       = acc_reg & rdata_reg[pend_bit_reg];
    assign result_load = (state_reg == ST_RUN) && pend_reg && pend_last_reg && out_free;
    assign out_valid     = out_valid_reg;
    assign maybe_present = maybe_reg;

    always_ff @(posedge clk)
    begin
        if (sweeping)
            mem[ctr_reg] <= '0;
        else if (q_pop && q_data.kind == bfm3_pkg::CMD_SET)
            mem[row][bitn] <= 1'b1;
        else if (q_pop && q_data.kind == bfm3_pkg::CMD_TEST)
            rdata_reg <= mem[row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ctr_reg       <= '0;
            pend_reg      <= 1'b0;
            acc_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_INIT, ST_CLR:
                begin
                    if (ctr_reg == LAST_ROW)
                    begin
                        ctr_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                    else
                        ctr_reg <= ctr_reg + RW'(1);
                end
                ST_RUN:
                begin
                    if (pend_reg)
                    begin
                        if (!pend_last_reg)
                        begin
                            acc_reg  <= hit;
                            pend_reg <= 1'b0;
                        end
                        else if (out_free)
                        begin
                            acc_reg       <= 1'b1;
                            pend_reg      <= 1'b0;
                        end
                    end
                    if (q_pop)
                    begin
                        case (q_data.kind)
                            bfm3_pkg::CMD_TEST:  pend_reg  <= 1'b1;
                            bfm3_pkg::CMD_CLEAR: state_reg <= ST_CLR;
                            default:             ;
                        endcase
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pend_last_reg <= q_data.last;
            pend_bit_reg  <= bitn;
        end
        if (result_load)
            maybe_reg <= hit;
    end

    a_no_pop_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping |-> !q_pop) else $error("command taken during sweep");
    a_no_pop_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !q_pop) else $error("command taken while a test is pending");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pend_last_reg && !out_free) |=> pend_reg)
        else $error("query result dropped");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the bloom filter murmur3 core
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int N_HASH    = 4;
    localparam int N_BITS    = 65536;
    localparam int N_AW      = $clog2(N_BITS);
    localparam int N_RANDOM  = 1900;
    localparam int WDOG_MAX  = 200000;
    localparam int DRAIN_CYC = 400;
    localparam logic [3:0] CFG_BAD_INDEX = 4'd9;

    // one stimulus word with its payload
    typedef struct {
        bfm3_pkg::action_t act;
        logic [31:0]       kw [bfm3_pkg::KEY_WORDS];
    } key_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] key_word0, key_word1, key_word2, key_word3, key_word4;
    logic        out_valid;
    logic        out_stall;
    logic        maybe_present;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_data;

    bloom_filter_murmur3_core #(
        .NUM_HASHES  (N_HASH),
        .FILTER_BITS (N_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .key_word0     (key_word0),
        .key_word1     (key_word1),
        .key_word2     (key_word2),
        .key_word3     (key_word3),
        .key_word4     (key_word4),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .maybe_present (maybe_present),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow copy of the filter and the seed registers
    logic        shadow_bits [N_BITS];
    logic [31:0] shadow_seed [bfm3_pkg::NUM_SEEDS];
    logic        answer_q [$];
    int          mismatch_cnt;
    int          idle_cnt;
    bit          rx_calm;       // no receiver stalls in the last part
    bit          rx_hold_req;   // ask the receiver for a long hold-off
    bit          rx_hold_done;

    // -------------------------------------------------------------------
    // murmur3 x86_32 predictor
    // -------------------------------------------------------------------
    function automatic logic [31:0] rol32(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] murmur_of_key(logic [31:0] kw [bfm3_pkg::KEY_WORDS],
                                                  logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        h = seed;
        for (int i = 0; i < bfm3_pkg::KEY_WORDS; i++)
        begin
            k = kw[i] * bfm3_pkg::MUR_C1;
            k = rol32(k, 15);
            k = k * bfm3_pkg::MUR_C2;
            h = h ^ k;
            h = rol32(h, 13);
            h = h * 32'd5 + bfm3_pkg::MUR_ADD;
        end
        h = h ^ bfm3_pkg::KEY_LEN;
        h = h ^ (h >> 16);
        h = h * bfm3_pkg::MUR_F1;
        h = h ^ (h >> 13);
        h = h * bfm3_pkg::MUR_F2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // bit address of one hash, reduced modulo the filter size
    function automatic logic [N_AW-1:0] bit_addr(logic [31:0] kw [bfm3_pkg::KEY_WORDS],
                                                 logic [31:0] seed);
        logic [31:0] a;
        a = murmur_of_key(kw, seed) % N_BITS;
        return a[N_AW-1:0];
    endfunction

    // apply one accepted word to the shadow filter, queue any answer
    task automatic apply_to_shadow(key_word_t w);
        logic [N_AW-1:0] addr;
        logic            all_set;
        all_set = 1'b1;
        case (w.act)
            bfm3_pkg::ACT_INSERT, bfm3_pkg::ACT_QUERY:
            begin
                for (int n = 0; n < N_HASH; n++)
                begin
                    addr = bit_addr(w.kw, shadow_seed[n]);
                    if (w.act == bfm3_pkg::ACT_INSERT)
                        shadow_bits[addr] = 1'b1;
                    else
                        all_set &= shadow_bits[addr];
                end
                if (w.act == bfm3_pkg::ACT_QUERY)
                    answer_q.push_back(all_set);
            end
            bfm3_pkg::ACT_CLEAR:
                for (int a = 0; a < N_BITS; a++)
                    shadow_bits[a] = 1'b0;
            default: ;   // unused code does nothing
        endcase
    endtask

    task automatic report_mismatch(string what, logic got, logic want);
        mismatch_cnt++;
        $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $realtime);
    endtask

    // -------------------------------------------------------------------
    // clock and reset
    // -------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // -------------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request
    // -------------------------------------------------------------------
    initial
    begin
        int burst;
        out_stall = 1'b0;
        rx_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req && !rx_hold_done)
            begin
                // long hold-off so the command queue fills and in_stall rises
                out_stall = 1'b1;
                repeat (600) @(negedge clk);
                out_stall = 1'b0;
                rx_hold_done = 1'b1;
            end
            else if (!rx_calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 6);
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------
    // checker and watchdog, sampled at the rising edge
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("unexpected answer word", maybe_present, 1'bx);
                else
                begin
                    want = answer_q.pop_front();
                    if (maybe_present !== want)
                        report_mismatch("maybe_present", maybe_present, want);
                end
            end
            if (idle_cnt >= WDOG_MAX)
            begin
                $display("watchdog expired, %0d answers outstanding", answer_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // -------------------------------------------------------------------
    // sender helpers
    // -------------------------------------------------------------------
    task automatic send_word(key_word_t w, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= w.act;
        key_word0 <= w.kw[0];
        key_word1 <= w.kw[1];
        key_word2 <= w.kw[2];
        key_word3 <= w.kw[3];
        key_word4 <= w.kw[4];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_to_shadow(w);
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // wait for all answers plus a full queue of trailing clears
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat ((N_BITS / 32 + 100) * 6) @(negedge clk);
    endtask

    task automatic write_seed(logic [3:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < bfm3_pkg::NUM_SEEDS)
            shadow_seed[idx[2:0]] = val;
    endtask

    function automatic key_word_t rand_key(bfm3_pkg::action_t a);
        key_word_t w;
        w.act = a;
        for (int i = 0; i < bfm3_pkg::KEY_WORDS; i++)
            w.kw[i] = $urandom;
        return w;
    endfunction

    // -------------------------------------------------------------------
    // directed table: action, key, answer typed in where obvious
    // ---------------------------------------------------------------------
    typedef struct {
        bfm3_pkg::action_t act;
        logic [31:0]       fill;   // every key word takes this value
        bit                known;  // answer can be read off directly
        logic              answer;
    } dir_row_t;

    dir_row_t dir_tab [17] = '{
        '{bfm3_pkg::ACT_QUERY,  32'h0000_0000, 1, 1'b0},  // empty filter after reset
        '{bfm3_pkg::ACT_QUERY,  32'hffff_ffff, 1, 1'b0},
        '{bfm3_pkg::ACT_INSERT, 32'h0000_0000, 0, 1'b0},
        '{bfm3_pkg::ACT_QUERY,  32'h0000_0000, 1, 1'b1},  // just inserted
        '{bfm3_pkg::ACT_INSERT, 32'hffff_ffff, 0, 1'b0},
        '{bfm3_pkg::ACT_QUERY,  32'hffff_ffff, 1, 1'b1},
        '{bfm3_pkg::ACT_QUERY,  32'h8000_0001, 0, 1'b0},
        '{bfm3_pkg::ACT_NONE,   32'h1234_5678, 0, 1'b0},  // unused code, no answer
        '{bfm3_pkg::ACT_QUERY,  32'h0000_0000, 1, 1'b1},
        '{bfm3_pkg::ACT_CLEAR,  32'hdead_beef, 0, 1'b0},  // key ignored on clear
        '{bfm3_pkg::ACT_QUERY,  32'h0000_0000, 1, 1'b0},  // cleared
        '{bfm3_pkg::ACT_QUERY,  32'hffff_ffff, 1, 1'b0},
        '{bfm3_pkg::ACT_INSERT, 32'h5555_5555, 0, 1'b0},
        '{bfm3_pkg::ACT_INSERT, 32'haaaa_aaaa, 0, 1'b0},
        '{bfm3_pkg::ACT_QUERY,  32'h5555_5555, 1, 1'b1},
        '{bfm3_pkg::ACT_QUERY,  32'haaaa_aaaa, 1, 1'b1},
        '{bfm3_pkg::ACT_QUERY,  32'h0000_0001, 0, 1'b0}
    };

    // -------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------
    initial
    begin
        key_word_t w;
        key_word_t pool [$];
        int        pick;
        logic      want;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = bfm3_pkg::ACT_INSERT;
        key_word0    = '0;
        key_word1    = '0;
        key_word2    = '0;
        key_word3    = '0;
        key_word4    = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatch_cnt = 0;
        idle_cnt     = 0;
        rx_calm      = 1'b0;
        rx_hold_req  = 1'b0;
        for (int a = 0; a < N_BITS; a++)
            shadow_bits[a] = 1'b0;
        for (int i = 0; i < bfm3_pkg::NUM_SEEDS; i++)
            shadow_seed[i] = i;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part with reset seeds
        foreach (dir_tab[r])
        begin
            w.act = dir_tab[r].act;
            for (int i = 0; i < bfm3_pkg::KEY_WORDS; i++)
                w.kw[i] = dir_tab[r].fill;
            // cross-check the typed answer against the predictor
            if (dir_tab[r].known && dir_tab[r].act == bfm3_pkg::ACT_QUERY)
            begin
                want = 1'b1;
                for (int n = 0; n < N_HASH; n++)
                    want &= shadow_bits[bit_addr(w.kw, shadow_seed[n])];
                if (want !== dir_tab[r].answer)
                    report_mismatch("table row", want, dir_tab[r].answer);
            end
            send_word(w, 1'b0);
        end
        wait_drained();

        // seeds at the extremes, plus an out of range index
        write_seed(0, 32'h0000_0000);
        write_seed(1, 32'hffff_ffff);
        write_seed(2, 32'h8000_0000);
        write_seed(3, 32'h7fff_ffff);
        write_seed(4, 32'hffff_ffff);
        write_seed(5, 32'h0000_0000);
        write_seed(6, $urandom);
        write_seed(7, $urandom);
        write_seed(CFG_BAD_INDEX, 32'hffff_ffff);

        // random phases, each with its own seed setting
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                for (int i = 0; i < bfm3_pkg::NUM_SEEDS; i++)
                    write_seed(i[3:0], (ph == 3) ? 32'hffff_ffff - i : $urandom);
                write_seed(4'd15, $urandom);
            end
            if (ph == 3)
                rx_calm = 1'b1;   // no idling in the last part
            pool.delete();
            for (int k = 0; k < N_RANDOM / 4; k++)
            begin
                if (ph == 1 && k == 40)
                    rx_hold_req = 1'b1;
                if (ph == 2 && k == 200)
                begin
                    // sender waits until every answer has come back
                    go_idle();
                    while (answer_q.size() != 0)
                        @(negedge clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    w = rand_key(bfm3_pkg::ACT_INSERT);
                    if ($urandom_range(0, 7) == 0)
                        for (int i = 0; i < bfm3_pkg::KEY_WORDS; i++)
                            w.kw[i] = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
                    pool.push_back(w);
                end
                else if (pick < 92)
                begin
                    // query a key already inserted about half the time, else a random key
                    if (pool.size() != 0 && $urandom_range(0, 1))
                    begin
                        w = pool[$urandom_range(0, pool.size() - 1)];
                        w.act = bfm3_pkg::ACT_QUERY;
                    end
                    else
                        w = rand_key(bfm3_pkg::ACT_QUERY);
                end
                else if (pick < 95)
                begin
                    w = rand_key(bfm3_pkg::ACT_CLEAR);
                    pool.delete();
                end
                else
                    w = rand_key(bfm3_pkg::ACT_NONE);
                send_word(w, !rx_calm);
            end
        end

        // drain with a limit
        go_idle();
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        if (mismatch_cnt == 0 && answer_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
